/* rtl/ple_pkg.sv */
// Shared types and codes for the positional list engine.
package ple_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One request item
  typedef struct packed {
    cmd_e        cmd;
    logic [6:0]  position;
    logic [31:0] value;
  } req_t;

  // One result item
  typedef struct packed {
    status_e     status;
    logic [31:0] data_out;
    logic [6:0]  found_index;
    logic [6:0]  length;
  } rsp_t;

  // Per-cell control decoded from the broadcast request
  typedef struct packed {
    logic ld_value;  // take the inserted word
    logic ld_left;   // shift toward the tail (insert)
    logic ld_right;  // shift toward the head (delete)
    logic sel;       // this cell is the addressed element
    logic live;      // this cell takes part in a search
  } cell_ctl_t;

endpackage

/* rtl/ple_cell.sv */
// One storage cell of the list chain: holds one element, shifts, matches.
module ple_cell import ple_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_ctl_t             ctl_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o,
  output logic [DATA_WIDTH-1:0] pick_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  hit_q, hit_d;
  logic [DATA_WIDTH-1:0] pick_q, pick_d;

  // next element word: insert, shift in from either neighbor, or hold
  always_comb begin
    data_d = data_q;
    if (ctl_i.ld_value) begin
      data_d = value_i;
    end else if (ctl_i.ld_left) begin
      data_d = left_i;
    end else if (ctl_i.ld_right) begin
      data_d = right_i;
    end
    hit_d  = ctl_i.live && (data_q == value_i);
    pick_d = ctl_i.sel ? data_q : '0;
  end

  // element word and the flags that the resolve stage reads
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
    pick_q <= pick_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;
  assign pick_o = pick_q;

endmodule

/* rtl/positional_list_engine_top.sv */
// Top level of the positional list engine: control, cell chain, resolve.
//
// Ordered list of up to CAPACITY words addressed by 1-based position.
// Requests: insert after element k (k = 0 puts it at the front), delete
// element k, find element k, search for the first element equal to value.
// A request item is taken at a rising edge with start high and busy low.
// Each request gives exactly one result item, shown on rsp_o for one cycle
// with done_o high; the receiver cannot stall and must take it then.
// The result passes in order through the broadcast stage, the cell and stage-two
// registers, and the result register. A new item is taken only once busy is low
// again, so items are never taken back to back. The broadcast stage sends the request to
// every cell of the chain; at the next edge all cells shift, load or compare
// in parallel and busy drops, while the registered match flags and pick words are
// merged by the resolve stage (lowest-hit index and OR of the addressed word).
// Every result carries the list length after the operation.
// Reset empties the list (length 0); element words need no clearing since
// only entries below the length are ever read.
module positional_list_engine_top import ple_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  // stage one: broadcast request
  logic                  s1_q;
  cmd_e                  cmd_q;
  logic [6:0]            pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [63:0]           val_wide;
  logic                  accept;

  assign accept   = start && !s1_q;
  assign busy     = s1_q;
  assign val_wide = 64'(req_i.value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else begin
      s1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.cmd;
      pos_q <= req_i.position;
      val_q <= val_wide[DATA_WIDTH-1:0];
    end
  end

  // range checks against the current length
  logic [PW-1:0] posx, cntx;
  logic          ins_ok, del_ok, find_ok, srch;
  status_e       status_d;

  assign posx = PW'(pos_q);
  assign cntx = PW'(cnt_q);

  always_comb begin
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    find_ok  = 1'b0;
    srch     = 1'b0;
    status_d = ST_OK;
    cnt_d    = cnt_q;
    case (cmd_q)
      CMD_INSERT: begin
        if (posx > cntx) begin
          status_d = ST_RANGE;
        end else if (cntx >= CAP_P) begin
          status_d = ST_FULL;
        end else begin
          ins_ok = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (posx == '0 || posx > cntx) begin
          status_d = ST_RANGE;
        end else begin
          del_ok = 1'b1;
          cnt_d  = cnt_q - CW'(1);
        end
      end
      CMD_FIND: begin
        if (posx == '0 || posx > cntx) begin
          status_d = ST_RANGE;
        end else begin
          find_ok = 1'b1;
        end
      end
      default: begin
        srch = 1'b1;
      end
    endcase
    if (!s1_q) begin
      ins_ok  = 1'b0;
      del_ok  = 1'b0;
      find_ok = 1'b0;
      srch    = 1'b0;
      cnt_d   = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // cell chain
  cell_ctl_t             ctl      [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_data[CAPACITY];
  logic [DATA_WIDTH-1:0] cell_pick[CAPACITY];
  logic [CAPACITY-1:0]   hit_vec;
  logic [CAPACITY-1:0]   sel_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [PW-1:0] IDX  = PW'(i);
    localparam logic [PW-1:0] IDX1 = PW'(i + 1);
    logic [DATA_WIDTH-1:0] left_w, right_w;

    always_comb begin
      ctl[i].ld_value = ins_ok && (IDX == posx);
      ctl[i].ld_left  = ins_ok && (IDX > posx) && (IDX <= cntx);
      ctl[i].ld_right = del_ok && (IDX1 >= posx) && (IDX1 < cntx);
      ctl[i].sel      = (del_ok || find_ok) && (IDX1 == posx);
      ctl[i].live     = srch && (IDX < cntx);
    end

    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end

    assign sel_vec[i] = ctl[i].sel;

    ple_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[i]),
      .value_i(val_q),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_data[i]),
      .hit_o  (hit_vec[i]),
      .pick_o (cell_pick[i])
    );
  end

  // stage two: status and length held for the resolve
  logic       s2_q;
  status_e    st2_q;
  logic [6:0] len2_q;
  logic [PW-1:0] cnt_next_x;

  assign cnt_next_x = PW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= 1'b0;
    end else begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      st2_q  <= status_d;
      len2_q <= cnt_next_x[6:0];
    end
  end

  // resolve: first matching cell and the picked word
  logic [CAPACITY-1:0]   first_vec;
  logic [PW-1:0]         idx_acc;
  logic [DATA_WIDTH-1:0] pick_acc;
  logic [63:0]           pick_wide;

  assign first_vec = hit_vec & (~hit_vec + {{(CAPACITY-1){1'b0}}, 1'b1});

  always_comb begin
    idx_acc  = '0;
    pick_acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      idx_acc  = idx_acc | (first_vec[i] ? PW'(i + 1) : '0);
      pick_acc = pick_acc | cell_pick[i];
    end
  end

  assign pick_wide = 64'(pick_acc);

  // result register
  logic done_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q) begin
      rsp_q.status      <= st2_q;
      rsp_q.data_out    <= pick_wide[31:0];
      rsp_q.found_index <= idx_acc[6:0];
      rsp_q.length      <= len2_q;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  // every broadcast request produces one result through the stage-two and result registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |=> ##1 done_q)
    else $error("request broadcast without a result");

  // the broadcast stage never holds two requests back to back
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |=> !s1_q)
    else $error("request accepted while busy");

  // length stays within capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(cnt_q) <= CAP_P)
    else $error("element count above capacity");

  // at most one cell is addressed
  a_one_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_vec))
    else $error("more than one cell addressed");

  // the length changes only while a request is broadcast
  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_q |=> $stable(cnt_q))
    else $error("length changed without a request");
`endif

endmodule

/* verif/ple_checker.sv */
// Result checker for the positional list engine: shadow list, expected-result queue, compare.
module ple_checker import ple_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  req_t       req_i,
  input  logic       done_i,
  input  rsp_t       rsp_i,
  output int         err_cnt_o,
  output int         pend_cnt_o,
  output int         rsp_cnt_o,
  output int         full_cnt_o,
  output int         range_cnt_o,
  output logic [6:0] len_o
);

  // Shadow copy of the list contents, head at index 0
  logic [31:0] list_words[$];
  // Results still owed by the block, oldest first
  rsp_t        owed_rsp[$];
  rsp_t        exp_rsp;
  rsp_t        new_rsp;
  int          errs;
  int          rsps;
  int          fulls;
  int          ranges;

  // Apply one request to the shadow list and return the result it should give
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    int unsigned pos;
    int unsigned hit;
    o        = '0;
    o.status = ST_OK;
    pos      = {25'b0, r.position};
    hit      = 0;
    case (r.cmd)
      CMD_INSERT: begin
        // position check wins over the full check
        if (pos > list_words.size()) o.status = ST_RANGE;
        else if (list_words.size() >= CAPACITY) o.status = ST_FULL;
        else list_words.insert(pos, r.value);
      end
      CMD_DELETE: begin
        if (pos < 1 || pos > list_words.size()) begin
          o.status = ST_RANGE;
        end else begin
          o.data_out = list_words[pos - 1];
          list_words.delete(pos - 1);
        end
      end
      CMD_FIND: begin
        if (pos < 1 || pos > list_words.size()) o.status = ST_RANGE;
        else o.data_out = list_words[pos - 1];
      end
      default: begin
        // first match from the head; position is ignored
        for (int i = 0; i < list_words.size() && hit == 0; i++)
          if (list_words[i] == r.value) hit = i + 1;
        o.found_index = 7'(hit);
      end
    endcase
    o.length = 7'(list_words.size());
    return o;
  endfunction

  // Compare results as they come out, then queue the prediction for a newly taken item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_words.delete();
      owed_rsp.delete();
      errs        = 0;
      rsps        = 0;
      fulls       = 0;
      ranges      = 0;
      err_cnt_o   <= 0;
      pend_cnt_o  <= 0;
      rsp_cnt_o   <= 0;
      full_cnt_o  <= 0;
      range_cnt_o <= 0;
      len_o       <= '0;
    end else begin
      if (done_i) begin
        rsps++;
        if (owed_rsp.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] ERROR: result with nothing expected: st=%0d data=%h idx=%0d len=%0d",
                     $realtime, rsp_i.status, rsp_i.data_out, rsp_i.found_index, rsp_i.length);
        end else begin
          exp_rsp = owed_rsp.pop_front();
          if (rsp_i !== exp_rsp) begin
            errs++;
            if (errs <= 10)
              $display({"[%0t] ERROR: exp st=%0d data=%h idx=%0d len=%0d, ",
                        "got st=%0d data=%h idx=%0d len=%0d"},
                       $realtime, exp_rsp.status, exp_rsp.data_out, exp_rsp.found_index,
                       exp_rsp.length, rsp_i.status, rsp_i.data_out, rsp_i.found_index,
                       rsp_i.length);
          end
        end
      end
      if (start_i && !busy_i) begin
        new_rsp = apply_request(req_i);
        if (new_rsp.status == ST_FULL) fulls++;
        if (new_rsp.status == ST_RANGE) ranges++;
        owed_rsp.push_back(new_rsp);
      end
      err_cnt_o   <= errs;
      pend_cnt_o  <= owed_rsp.size();
      rsp_cnt_o   <= rsps;
      full_cnt_o  <= fulls;
      range_cnt_o <= ranges;
      len_o       <= 7'(list_words.size());
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the positional list engine: clock, reset, request stimulus, verdict.
module tb_top;
  import ple_pkg::*;

  localparam int CAPACITY  = 64;
  localparam int N_RANDOM  = 1550;
  localparam int EPOCH_LEN = 160;

  logic       clk     = 1'b0;
  logic       rst_n   = 1'b0;
  logic       start   = 1'b0;
  req_t       req     = '0;
  logic       busy;
  logic       done;
  rsp_t       rsp;

  int         err_cnt;
  int         pend_cnt;
  int         rsp_cnt;
  int         full_cnt;
  int         range_cnt;
  logic [6:0] list_len;

  int          cmd_cnt [4];
  logic [31:0] word_pool [8];
  int          wait_cyc;

  always #4 clk = ~clk;

  positional_list_engine_top #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .rsp_o (rsp)
  );

  ple_checker #(
    .CAPACITY(CAPACITY)
  ) list_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req),
    .done_i     (done),
    .rsp_i      (rsp),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt),
    .rsp_cnt_o  (rsp_cnt),
    .full_cnt_o (full_cnt),
    .range_cnt_o(range_cnt),
    .len_o      (list_len)
  );

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Hold start low for gap cycles, then present the item until it is taken
  task automatic send_item(input cmd_e c, input logic [6:0] p, input logic [31:0] v,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    req.cmd      <= c;
    req.position <= p;
    req.value    <= v;
    do @(posedge clk); while (busy !== 1'b0);
    cmd_cnt[c]++;
  endtask

  // Pick one random request; grow phases favor inserts, shrink phases deletes
  task automatic send_random(input bit grow, input int gap);
    int unsigned w;
    int unsigned len;
    cmd_e        c;
    logic [6:0]  p;
    logic [31:0] v;
    w   = $urandom_range(0, 99);
    len = {25'b0, list_len};
    if (grow)
      c = (w < 60) ? CMD_INSERT : (w < 75) ? CMD_DELETE : (w < 88) ? CMD_FIND : CMD_SEARCH;
    else
      c = (w < 15) ? CMD_INSERT : (w < 70) ? CMD_DELETE : (w < 85) ? CMD_FIND : CMD_SEARCH;
    // mostly legal positions, some noise over the whole field
    if ($urandom_range(0, 9) == 0) p = 7'($urandom_range(0, 127));
    else if (c == CMD_INSERT) p = 7'($urandom_range(0, len));
    else if (len == 0) p = 7'($urandom_range(0, 1));
    else p = 7'($urandom_range(1, len));
    // pool words give duplicates and search hits
    if ($urandom_range(0, 9) < ((c == CMD_SEARCH) ? 7 : 5)) v = word_pool[$urandom_range(0, 7)];
    else v = $urandom;
    send_item(c, p, v, gap);
  endtask

  initial begin
    bit grow;
    bit burst;
    int gap;
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < 8; i++) word_pool[i] = $urandom;
    foreach (cmd_cnt[i]) cmd_cnt[i] = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, ends and middle, out-of-range positions, duplicates
    send_item(CMD_FIND,   7'd1,   32'h0,        $urandom_range(0, 13));
    send_item(CMD_DELETE, 7'd1,   32'h0,        $urandom_range(0, 13));
    send_item(CMD_SEARCH, 7'd0,   32'h0,        $urandom_range(0, 13));
    send_item(CMD_INSERT, 7'd1,   32'h1,        $urandom_range(0, 13));
    send_item(CMD_INSERT, 7'd0,   32'h0,        0);
    send_item(CMD_INSERT, 7'd1,   32'hFFFF_FFFF, 0);
    send_item(CMD_INSERT, 7'd0,   32'hA5A5_A5A5, $urandom_range(0, 13));
    send_item(CMD_INSERT, 7'd2,   32'h5A5A_5A5A, 0);
    send_item(CMD_INSERT, 7'd127, 32'h0,        0);
    send_item(CMD_FIND,   7'd0,   32'h0,        $urandom_range(0, 13));
    send_item(CMD_FIND,   7'd1,   32'h0,        0);
    send_item(CMD_FIND,   7'd4,   32'h0,        0);
    send_item(CMD_FIND,   7'd5,   32'h0,        $urandom_range(0, 13));
    send_item(CMD_FIND,   7'd127, 32'h0,        0);
    send_item(CMD_SEARCH, 7'd0,   32'hFFFF_FFFF, 0);
    send_item(CMD_SEARCH, 7'd127, 32'h0,        $urandom_range(0, 13));
    send_item(CMD_SEARCH, 7'd3,   32'h1234_5678, 0);
    send_item(CMD_INSERT, 7'd0,   32'hFFFF_FFFF, 0);
    send_item(CMD_SEARCH, 7'd0,   32'hFFFF_FFFF, 0);
    send_item(CMD_DELETE, 7'd0,   32'h0,        $urandom_range(0, 13));
    send_item(CMD_DELETE, 7'd127, 32'h0,        0);
    send_item(CMD_DELETE, 7'd5,   32'h0,        0);
    send_item(CMD_DELETE, 7'd1,   32'h0,        $urandom_range(0, 13));
    send_item(CMD_DELETE, 7'd4,   32'h0,        0);

    // Random: alternate fill and drain phases so the list hits full and empty
    grow  = 1'b0;
    burst = 1'b0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % EPOCH_LEN == 0) grow = ~grow;
      if (k % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 13);
      send_random(grow, gap);
    end
    start <= 1'b0;

    // Drain outstanding results, then keep the clock running to catch stray strobes
    wait_cyc = 0;
    while (pend_cnt != 0 && wait_cyc < 1000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d requests: %0d insert, %0d delete, %0d find, %0d search; %0d results seen",
             cmd_cnt[0] + cmd_cnt[1] + cmd_cnt[2] + cmd_cnt[3], cmd_cnt[CMD_INSERT],
             cmd_cnt[CMD_DELETE], cmd_cnt[CMD_FIND], cmd_cnt[CMD_SEARCH], rsp_cnt);
    $display("Rejected inserts on a full list: %0d, out-of-range requests: %0d, mismatches: %0d",
             full_cnt, range_cnt, err_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
